### hdl/cbsf_pkg.sv
// Package for the cell brightness and slope features block.
// Fixed field widths, register reset value, sequencer states and divider status.
// No dependencies.
package cbsf_pkg;

  localparam int PIX_W     = 8;
  localparam int IDX_W     = 4;
  localparam int BRT_W     = 8;
  localparam int RAT_W     = 13;
  localparam int SLP_W     = 17;
  localparam int LEN_CFG_W = 4;
  localparam int FRAC_SH   = 9;
  localparam int RAT_SH    = 8;

  localparam logic [LEN_CFG_W-1:0] LEN_RST = 4'd2;

  typedef enum logic [12:0] {
    S_LOAD  = 13'b0000000000001,
    S_FDIV  = 13'b0000000000010,
    S_FWAIT = 13'b0000000000100,
    S_MUL1  = 13'b0000000001000,
    S_MUL2  = 13'b0000000010000,
    S_DX    = 13'b0000000100000,
    S_DXW   = 13'b0000001000000,
    S_DY    = 13'b0000010000000,
    S_DYW   = 13'b0000100000000,
    S_RD    = 13'b0001000000000,
    S_RDW   = 13'b0010000000000,
    S_RTW   = 13'b0100000000000,
    S_EMIT  = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/cbsf_if.sv
// Handshake channels of the cell brightness and slope features block.
// Pixel input, sector result output and sector length write channel.
// Depends on cbsf_pkg.
interface cbsf_in_if;
  logic                        valid;
  logic                        ready;
  logic [cbsf_pkg::PIX_W-1:0]  pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface cbsf_out_if;
  logic                              valid;
  logic                              ready;
  logic [cbsf_pkg::IDX_W-1:0]        sector_index;
  logic [cbsf_pkg::BRT_W-1:0]        sector_brightness;
  logic [cbsf_pkg::RAT_W-1:0]        brightness_ratio;
  logic signed [cbsf_pkg::SLP_W-1:0] slope_x;
  logic signed [cbsf_pkg::SLP_W-1:0] slope_y;
  logic                              last;
  modport source (output valid, output sector_index, output sector_brightness,
                  output brightness_ratio, output slope_x, output slope_y,
                  output last, input ready);
  modport sink (input valid, input sector_index, input sector_brightness,
                input brightness_ratio, input slope_x, input slope_y,
                input last, output ready);
endinterface

interface cbsf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cbsf_pkg::LEN_CFG_W-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/cbsf_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Unsigned dividend and divisor; pulses done with the quotient held.
// Depends on cbsf_pkg.
module cbsf_div #(
  parameter int DW = 40,
  parameter int VW = 21
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DW-1:0]       dividend,
  input  logic [VW-1:0]       divisor,
  output logic [DW-1:0]       quotient,
  output cbsf_pkg::div_stat_t stat
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VW:0]      rem_r, rem_nxt;
  logic [DW-1:0]    quo_r, quo_nxt;
  logic [VW-1:0]    dvs_r, dvs_nxt;
  logic [VW:0]      rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r[VW-1:0], quo_r[DW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### hdl/cell_brightness_slope_features_core.sv
// Top level of the cell brightness and slope features block.
// Pixel accumulation, sector flush, finish sequencer and result register.
// Depends on cbsf_pkg, cbsf_if and cbsf_div.
// Pixels are taken one per cycle within a sector row. After each row of
// sectors, SECTOR_COLS divisions run in the shared divider (DW = accumulator
// width + 9, 33 at defaults), and no pixel is taken meanwhile. After the last
// pixel: two multiply steps, two slope divisions, then per sector a read, a
// ratio division unless the brightness sum is zero, and the result.
// Reset is synchronous: sector length 2, cell cleared, no result pending.
module cell_brightness_slope_features_core #(
  parameter int SECTOR_ROWS    = 4,
  parameter int SECTOR_COLS    = 4,
  parameter int MAX_SECTOR_LEN = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  cbsf_in_if.sink     in_ch,
  cbsf_out_if.source  out_ch,
  cbsf_cfg_if.sink    cfg_ch
);

  localparam int NSECT   = SECTOR_ROWS * SECTOR_COLS;
  localparam int W_MAX   = MAX_SECTOR_LEN * SECTOR_COLS;
  localparam int H_MAX   = MAX_SECTOR_LEN * SECTOR_ROWS;
  localparam int DIM_MAX = (W_MAX > H_MAX) ? W_MAX : H_MAX;
  localparam int LEN_W   = $clog2(MAX_SECTOR_LEN + 1);
  localparam int W_W     = $clog2(W_MAX + 1);
  localparam int H_W     = $clog2(H_MAX + 1);
  localparam int CW      = $clog2(W_MAX);
  localparam int RW      = $clog2(H_MAX);
  localparam int CFX_W   = W_W + 1;
  localparam int CFY_W   = H_W + 1;
  localparam int SC_W    = $clog2(SECTOR_COLS);
  localparam int NS_W    = $clog2(NSECT);
  localparam int SUM_W   = $clog2(MAX_SECTOR_LEN * MAX_SECTOR_LEN * 255 + 1);
  localparam longint ACC_BND = longint'(255) * W_MAX * H_MAX * DIM_MAX;
  localparam int ACC_W   = $clog2(ACC_BND + 1) + 1;
  localparam int HW_W    = $clog2(W_MAX * H_MAX + 1);
  localparam int HD_W    = $clog2(longint'(H_MAX) * W_MAX * DIM_MAX + 1);
  localparam int BS_W    = $clog2(255 * NSECT + 1);
  localparam int LSQ_W   = $clog2(MAX_SECTOR_LEN * MAX_SECTOR_LEN + 1);
  localparam int VW_A    = (HD_W > BS_W) ? HD_W : BS_W;
  localparam int VW      = (VW_A > LSQ_W) ? VW_A : LSQ_W;
  localparam int DW      = ACC_W + cbsf_pkg::FRAC_SH;

  cbsf_pkg::state_t state_r, state_nxt;

  logic [cbsf_pkg::LEN_CFG_W-1:0] len_cfg_r;
  logic [LEN_W-1:0]  len_e;
  logic [LSQ_W-1:0]  lensq_r;
  logic [W_W-1:0]    w_v;
  logic [H_W-1:0]    h_v;

  logic [CW-1:0]     c_r, c_nxt;
  logic [RW-1:0]     r_r, r_nxt;
  logic [LEN_W-1:0]  cin_r, cin_nxt;
  logic [LEN_W-1:0]  rin_r, rin_nxt;
  logic [SC_W-1:0]   sc_r, sc_nxt;
  logic              lrow_r, lrow_nxt;
  logic [SUM_W-1:0]  lane_r [SECTOR_COLS];
  logic signed [ACC_W-1:0] hacc_r, hacc_nxt;
  logic signed [ACC_W-1:0] vacc_r, vacc_nxt;
  logic [NS_W-1:0]   bidx_r, bidx_nxt;
  logic [BS_W-1:0]   bsum_r, bsum_nxt;
  logic [HW_W-1:0]   hw_r, hw_nxt;
  logic [HD_W-1:0]   hd_r, hd_nxt;
  logic [HD_W-1:0]   vd_r, vd_nxt;
  logic signed [cbsf_pkg::SLP_W-1:0] dx_r, dx_nxt;
  logic signed [cbsf_pkg::SLP_W-1:0] dy_r, dy_nxt;
  logic [NS_W-1:0]   ok_r, ok_nxt;
  logic [cbsf_pkg::RAT_W-1:0] rat_r, rat_nxt;

  logic [cbsf_pkg::BRT_W-1:0] bmem [NSECT];
  logic [cbsf_pkg::BRT_W-1:0] bq_r;

  logic              ov_r, ov_nxt;
  logic [cbsf_pkg::IDX_W-1:0] o_idx_r;
  logic [cbsf_pkg::BRT_W-1:0] o_brt_r;
  logic [cbsf_pkg::RAT_W-1:0] o_rat_r;
  logic signed [cbsf_pkg::SLP_W-1:0] o_dx_r, o_dy_r;
  logic              o_last_r;
  logic              o_load;

  logic              pix_acc, cfg_acc;
  logic [cbsf_pkg::PIX_W-1:0] pix;
  logic signed [CFX_W-1:0] cx;
  logic signed [CFY_W-1:0] cy;
  logic signed [CFX_W+cbsf_pkg::PIX_W:0] px;
  logic signed [CFY_W+cbsf_pkg::PIX_W:0] py;
  logic              lane_add, lane_clr;
  logic [ACC_W-1:0]  hmag, vmag;

  logic              div_start;
  logic [DW-1:0]     div_dvd;
  logic [VW-1:0]     div_dvs;
  logic [DW-1:0]     div_q;
  cbsf_pkg::div_stat_t div_st;

  cbsf_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .stat     (div_st)
  );

  always_comb begin
    if (len_cfg_r == '0) begin
      len_e = LEN_W'(1);
    end else if (int'(len_cfg_r) > MAX_SECTOR_LEN) begin
      len_e = LEN_W'(MAX_SECTOR_LEN);
    end else begin
      len_e = LEN_W'(len_cfg_r);
    end
  end

  assign w_v = W_W'(int'(len_e) * SECTOR_COLS);
  assign h_v = H_W'(int'(len_e) * SECTOR_ROWS);

  assign in_ch.ready  = (state_r == cbsf_pkg::S_LOAD);
  assign cfg_ch.ready = 1'b1;
  assign pix_acc      = in_ch.valid && in_ch.ready;
  assign cfg_acc      = cfg_ch.valid;
  assign pix          = in_ch.pixel;

  assign cx = $signed(CFX_W'(w_v - 1'b1)) - $signed(CFX_W'({c_r, 1'b0}));
  assign cy = $signed(CFY_W'(h_v - 1'b1)) - $signed(CFY_W'({r_r, 1'b0}));
  assign px = $signed({1'b0, pix}) * cx;
  assign py = $signed({1'b0, pix}) * cy;

  assign hmag = hacc_r[ACC_W-1] ? ACC_W'(-hacc_r) : ACC_W'(hacc_r);
  assign vmag = vacc_r[ACC_W-1] ? ACC_W'(-vacc_r) : ACC_W'(vacc_r);

  always_comb begin
    state_nxt = state_r;
    c_nxt     = c_r;
    r_nxt     = r_r;
    cin_nxt   = cin_r;
    rin_nxt   = rin_r;
    sc_nxt    = sc_r;
    lrow_nxt  = lrow_r;
    hacc_nxt  = hacc_r;
    vacc_nxt  = vacc_r;
    bidx_nxt  = bidx_r;
    bsum_nxt  = bsum_r;
    hw_nxt    = hw_r;
    hd_nxt    = hd_r;
    vd_nxt    = vd_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    ok_nxt    = ok_r;
    rat_nxt   = rat_r;
    ov_nxt    = ov_r && !out_ch.ready;
    o_load    = 1'b0;
    lane_add  = 1'b0;
    lane_clr  = 1'b0;
    div_start = 1'b0;
    div_dvd   = DW'(lane_r[sc_r]);
    div_dvs   = VW'(lensq_r);

    unique case (state_r)
      cbsf_pkg::S_LOAD: begin
        if (pix_acc) begin
          lane_add = 1'b1;
          hacc_nxt = hacc_r + ACC_W'(px);
          vacc_nxt = vacc_r + ACC_W'(py);
          if (W_W'(c_r) == w_v - 1'b1) begin
            c_nxt   = '0;
            cin_nxt = '0;
            sc_nxt  = '0;
            r_nxt   = (H_W'(r_r) == h_v - 1'b1) ? '0 : r_r + 1'b1;
            if (rin_r == len_e - 1'b1) begin
              rin_nxt   = '0;
              lrow_nxt  = (H_W'(r_r) == h_v - 1'b1);
              state_nxt = cbsf_pkg::S_FDIV;
            end else begin
              rin_nxt = rin_r + 1'b1;
            end
          end else begin
            c_nxt = c_r + 1'b1;
            if (cin_r == len_e - 1'b1) begin
              cin_nxt = '0;
              sc_nxt  = sc_r + 1'b1;
            end else begin
              cin_nxt = cin_r + 1'b1;
            end
          end
        end
      end
      cbsf_pkg::S_FDIV: begin
        div_start = 1'b1;
        state_nxt = cbsf_pkg::S_FWAIT;
      end
      cbsf_pkg::S_FWAIT: begin
        if (div_st.done) begin
          lane_clr = 1'b1;
          bsum_nxt = bsum_r + BS_W'(div_q[cbsf_pkg::BRT_W-1:0]);
          bidx_nxt = bidx_r + 1'b1;
          if (int'(sc_r) == SECTOR_COLS - 1) begin
            sc_nxt    = '0;
            state_nxt = lrow_r ? cbsf_pkg::S_MUL1 : cbsf_pkg::S_LOAD;
          end else begin
            sc_nxt    = sc_r + 1'b1;
            state_nxt = cbsf_pkg::S_FDIV;
          end
        end
      end
      cbsf_pkg::S_MUL1: begin
        hw_nxt    = HW_W'(h_v * w_v);
        ok_nxt    = '0;
        state_nxt = cbsf_pkg::S_MUL2;
      end
      cbsf_pkg::S_MUL2: begin
        hd_nxt    = HD_W'(hw_r * (w_v - 1'b1));
        vd_nxt    = HD_W'(hw_r * (h_v - 1'b1));
        state_nxt = cbsf_pkg::S_DX;
      end
      cbsf_pkg::S_DX: begin
        div_start = 1'b1;
        div_dvd   = {hmag, {cbsf_pkg::FRAC_SH{1'b0}}};
        div_dvs   = VW'(hd_r);
        state_nxt = cbsf_pkg::S_DXW;
      end
      cbsf_pkg::S_DXW: begin
        if (div_st.done) begin
          dx_nxt = hacc_r[ACC_W-1] ? -cbsf_pkg::SLP_W'(div_q)
                                   : cbsf_pkg::SLP_W'(div_q);
          state_nxt = cbsf_pkg::S_DY;
        end
      end
      cbsf_pkg::S_DY: begin
        div_start = 1'b1;
        div_dvd   = {vmag, {cbsf_pkg::FRAC_SH{1'b0}}};
        div_dvs   = VW'(vd_r);
        state_nxt = cbsf_pkg::S_DYW;
      end
      cbsf_pkg::S_DYW: begin
        if (div_st.done) begin
          dy_nxt = vacc_r[ACC_W-1] ? -cbsf_pkg::SLP_W'(div_q)
                                   : cbsf_pkg::SLP_W'(div_q);
          state_nxt = cbsf_pkg::S_RD;
        end
      end
      cbsf_pkg::S_RD: begin
        state_nxt = cbsf_pkg::S_RDW;
      end
      cbsf_pkg::S_RDW: begin
        if (bsum_r == '0) begin
          rat_nxt   = '0;
          state_nxt = cbsf_pkg::S_EMIT;
        end else begin
          div_start = 1'b1;
          div_dvd   = DW'(DW'(bq_r) * NSECT) << cbsf_pkg::RAT_SH;
          div_dvs   = VW'(bsum_r);
          state_nxt = cbsf_pkg::S_RTW;
        end
      end
      cbsf_pkg::S_RTW: begin
        if (div_st.done) begin
          rat_nxt   = cbsf_pkg::RAT_W'(div_q);
          state_nxt = cbsf_pkg::S_EMIT;
        end
      end
      cbsf_pkg::S_EMIT: begin
        if (!ov_r || out_ch.ready) begin
          o_load = 1'b1;
          ov_nxt = 1'b1;
          if (int'(ok_r) == NSECT - 1) begin
            hacc_nxt  = '0;
            vacc_nxt  = '0;
            bsum_nxt  = '0;
            bidx_nxt  = '0;
            state_nxt = cbsf_pkg::S_LOAD;
          end else begin
            ok_nxt    = ok_r + 1'b1;
            state_nxt = cbsf_pkg::S_RD;
          end
        end
      end
      default: state_nxt = cbsf_pkg::S_LOAD;
    endcase

    if (cfg_acc) begin
      state_nxt = cbsf_pkg::S_LOAD;
      c_nxt     = '0;
      r_nxt     = '0;
      cin_nxt   = '0;
      rin_nxt   = '0;
      sc_nxt    = '0;
      lrow_nxt  = 1'b0;
      hacc_nxt  = '0;
      vacc_nxt  = '0;
      bidx_nxt  = '0;
      bsum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cbsf_pkg::S_LOAD;
      len_cfg_r <= cbsf_pkg::LEN_RST;
      c_r       <= '0;
      r_r       <= '0;
      cin_r     <= '0;
      rin_r     <= '0;
      sc_r      <= '0;
      lrow_r    <= 1'b0;
      hacc_r    <= '0;
      vacc_r    <= '0;
      bidx_r    <= '0;
      bsum_r    <= '0;
      ok_r      <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      if (cfg_acc) begin
        len_cfg_r <= cfg_ch.data;
      end
      c_r       <= c_nxt;
      r_r       <= r_nxt;
      cin_r     <= cin_nxt;
      rin_r     <= rin_nxt;
      sc_r      <= sc_nxt;
      lrow_r    <= lrow_nxt;
      hacc_r    <= hacc_nxt;
      vacc_r    <= vacc_nxt;
      bidx_r    <= bidx_nxt;
      bsum_r    <= bsum_nxt;
      ok_r      <= ok_nxt;
      ov_r      <= ov_nxt;
    end
    lensq_r <= LSQ_W'(len_e * len_e);
    hw_r    <= hw_nxt;
    hd_r    <= hd_nxt;
    vd_r    <= vd_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    rat_r   <= rat_nxt;
  end

  for (genvar g = 0; g < SECTOR_COLS; g++) begin : g_lane
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lane_r[g] <= '0;
      end else if (cfg_acc) begin
        lane_r[g] <= '0;
      end else if (lane_add && (int'(sc_r) == g)) begin
        lane_r[g] <= lane_r[g] + SUM_W'(pix);
      end else if (lane_clr && (int'(sc_r) == g)) begin
        lane_r[g] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lane_clr) begin
      bmem[bidx_r] <= div_q[cbsf_pkg::BRT_W-1:0];
    end
    bq_r <= bmem[ok_r];
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_idx_r  <= cbsf_pkg::IDX_W'(ok_r);
      o_brt_r  <= bq_r;
      o_rat_r  <= rat_r;
      o_dx_r   <= dx_r;
      o_dy_r   <= dy_r;
      o_last_r <= (int'(ok_r) == NSECT - 1);
    end
  end

  assign out_ch.valid             = ov_r;
  assign out_ch.sector_index      = o_idx_r;
  assign out_ch.sector_brightness = o_brt_r;
  assign out_ch.brightness_ratio  = o_rat_r;
  assign out_ch.slope_x           = o_dx_r;
  assign out_ch.slope_y           = o_dy_r;
  assign out_ch.last              = o_last_r;

endmodule
